// File: hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } deq_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  // Control decision for one transaction, from the pointer logic to the ring.
  typedef struct packed {
    logic        wr_en;
    logic        rd_en;
    deq_status_t status;
  } deq_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/deq_if.sv
// Valid/ready channel interfaces for the queue's request and response sides.
`default_nettype none

interface deq_in_if
  import deq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  deq_op_t                  op;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

interface deq_out_if
  import deq_pkg::*;
  #(parameter int CNT_W = 5)
  ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] popped_value;
  deq_status_t              status;
  logic [CNT_W-1:0]         occupancy;

  modport source (output valid, popped_value, status, occupancy, input ready);
  modport sink   (input valid, popped_value, status, occupancy, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/deq_ctrl.sv
// Pointer logic: ring address, next front index and count, status per operation.
`default_nettype none

module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  deq_op_t                      op,
  input  logic [$clog2(DEPTH)-1:0]     front,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  output deq_ctl_t                     ctl,
  output logic [$clog2(DEPTH)-1:0]     addr,
  output logic [$clog2(DEPTH)-1:0]     front_nxt,
  output logic [$clog2(DEPTH+1)-1:0]   count_nxt
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic          full;
  logic          empty;
  logic [CW-1:0] rear_off;
  logic [SW-1:0] rear_sum;
  logic [AW-1:0] rear_pos;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Rear slot sits count words past the front; a pop takes the last one.
  assign rear_off = (op == OP_POP_REAR) ? count - CW'(1) : count;
  assign rear_sum = SW'(front) + SW'(rear_off);
  assign rear_pos = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);

  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);

  always_comb begin
    ctl.wr_en  = 1'b0;
    ctl.rd_en  = 1'b0;
    ctl.status = ST_OK;
    addr       = rear_pos;
    front_nxt  = front;
    count_nxt  = count;
    unique case (op)
      OP_PUSH_FRONT: begin
        addr = front_dec;
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.wr_en = 1'b1;
          front_nxt = front_dec;
          count_nxt = count + CW'(1);
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.wr_en = 1'b1;
          count_nxt = count + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        addr = front;
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.rd_en = 1'b1;
          front_nxt = front_inc;
          count_nxt = count - CW'(1);
        end
      end
      OP_POP_REAR: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.rd_en = 1'b1;
          count_nxt = count - CW'(1);
        end
      end
      default: begin
        ctl.status = ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/double_ended_queue_core.sv
// Top level of the double-ended queue: ring memory, index registers, response register.
`default_nettype none

// Double-ended queue of signed 32-bit words in a ring of DEPTH entries. Every
// request transaction (push front, push rear, pop front, pop rear) yields exactly
// one response transaction carrying the popped word (zero unless a pop succeeded),
// a status (ok, empty on pop, full on push) and the occupancy after the operation.
// A failed push drops its word; a failed pop changes nothing. One request is taken
// per cycle: the ring is a single-port synchronous memory touched once per request,
// written at the accept edge for a push and read at the accept edge for a pop, so
// the response appears in the cycle after acceptance and the next request can follow
// right behind it. in_ch.ready drops only while a response waits and out_ch.ready is
// low. The ring needs no clearing after reset: only written entries are ever read.

module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Ring storage, no reset.
  logic signed [WORD_W-1:0] ring_mem [DEPTH];

  // Queue state.
  logic [AW-1:0] front_r;
  logic [CW-1:0] count_r;

  // Response register.
  logic                     out_valid_r;
  logic                     pop_ok_r;
  logic signed [WORD_W-1:0] rd_data_r;
  deq_status_t              status_r;
  logic [CW-1:0]            occ_r;

  // Pointer logic outputs.
  deq_ctl_t      ctl;
  logic [AW-1:0] addr;
  logic [AW-1:0] front_nxt;
  logic [CW-1:0] count_nxt;

  logic in_fire;

  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .op        (in_ch.op),
    .front     (front_r),
    .count     (count_r),
    .ctl       (ctl),
    .addr      (addr),
    .front_nxt (front_nxt),
    .count_nxt (count_nxt)
  );

  // Accept whenever the response slot is free or being drained this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Ring memory: one access per transaction, registered read data.
  always_ff @(posedge clk) begin
    if (in_fire && ctl.wr_en) begin
      ring_mem[addr] <= in_ch.value;
    end
    if (in_fire && ctl.rd_en) begin
      rd_data_r <= ring_mem[addr];
    end
  end

  // Index/count state and response control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pop_ok_r    <= 1'b0;
      status_r    <= ST_OK;
      occ_r       <= '0;
    end else begin
      if (in_fire) begin
        front_r     <= front_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        pop_ok_r    <= ctl.rd_en;
        status_r    <= ctl.status;
        occ_r       <= count_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = pop_ok_r ? rd_data_r : '0;
  assign out_ch.status       = status_r;
  assign out_ch.occupancy    = occ_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Count never exceeds the ring size and the front index stays in range.
  a_state_range : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CW'(DEPTH)) && (front_r <= AW'(DEPTH - 1)))
    else $error("queue state out of range");

  // A pop on an empty queue reports empty and keeps the count.
  a_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (count_r == '0) &&
     ((in_ch.op == OP_POP_FRONT) || (in_ch.op == OP_POP_REAR)))
    |=> (out_ch.status == ST_EMPTY) && (count_r == '0) && (out_ch.popped_value == '0))
    else $error("empty pop mishandled");

  // A push into a full queue reports full and leaves front and count alone.
  a_push_full : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (count_r == CW'(DEPTH)) &&
     ((in_ch.op == OP_PUSH_FRONT) || (in_ch.op == OP_PUSH_REAR)))
    |=> (out_ch.status == ST_FULL) && $stable(front_r) && (count_r == CW'(DEPTH)))
    else $error("full push mishandled");

  // A successful push grows the occupancy by exactly one.
  a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (count_r != CW'(DEPTH)) &&
     ((in_ch.op == OP_PUSH_FRONT) || (in_ch.op == OP_PUSH_REAR)))
    |=> (out_ch.occupancy == $past(count_r) + CW'(1)) && (out_ch.status == ST_OK))
    else $error("push occupancy wrong");

endmodule

`default_nettype wire

// File: tb/double_ended_queue_core_tb.sv
// Self-checking testbench for the double-ended queue core.
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
  import deq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int CNT_W      = 5;
  localparam int RAND_ITEMS = 400;
  localparam int QUIET_TAIL = 50;   // last transactions run without any idling
  localparam int DRAIN_WAIT = 20;   // cycles allowed after the last response

  typedef struct {
    deq_op_t                  op;
    logic signed [WORD_W-1:0] value;
    bit                       drain_first;  // hold until every response is back
  } deq_req_t;

  typedef struct {
    logic signed [WORD_W-1:0] popped_value;
    deq_status_t              status;
    logic [CNT_W-1:0]         occupancy;
  } deq_resp_t;

  logic clk;
  logic rst_n;

  deq_in_if                   in_ch ();
  deq_out_if #(.CNT_W(CNT_W)) out_ch ();

  double_ended_queue_core #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Requests waiting to be driven, filled once at time zero.
  deq_req_t  pending_req_q[$];
  // Responses predicted for accepted requests, oldest first.
  deq_resp_t expected_resp_q[$];

  int total_reqs;
  int n_sent;       // accepted requests (updated with NBA so the driver sees a stable value)
  int n_recv;       // accepted responses
  int err_count;
  int gen_count;    // occupancy as tracked while building the stimulus
  bit hold_next;

  // Shadow copy of the queue state.
  logic signed [WORD_W-1:0] ring_mdl [DEPTH];
  int                       front_mdl;
  int                       count_mdl;

  // Coverage tallies for the closing summary.
  int n_push, n_pop, n_full, n_empty, peak_occ;

  // Apply one operation to the shadow queue and return the response it must produce.
  function automatic deq_resp_t deq_apply_op(deq_op_t op, logic signed [WORD_W-1:0] word);
    deq_resp_t r;
    int        pos;
    r.popped_value = '0;
    r.status       = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (count_mdl >= DEPTH) begin
          r.status = ST_FULL;  // word is dropped
        end else if (op == OP_PUSH_FRONT) begin
          front_mdl = (front_mdl + DEPTH - 1) % DEPTH;
          ring_mdl[front_mdl] = word;
          count_mdl++;
        end else begin
          ring_mdl[(front_mdl + count_mdl) % DEPTH] = word;
          count_mdl++;
        end
      end
      default: begin
        if (count_mdl == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          r.popped_value = ring_mdl[front_mdl];
          front_mdl = (front_mdl + 1) % DEPTH;
          count_mdl--;
        end else begin
          pos = (front_mdl + count_mdl - 1) % DEPTH;
          r.popped_value = ring_mdl[pos];
          count_mdl--;
        end
      end
    endcase
    r.occupancy = count_mdl[CNT_W-1:0];
    return r;
  endfunction

  // Random word, biased toward the corners of the signed range.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_req(deq_op_t op, logic signed [WORD_W-1:0] v);
    deq_req_t r;
    r.op          = op;
    r.value       = v;
    r.drain_first = hold_next;
    hold_next     = 0;
    pending_req_q.push_back(r);
    if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
      if (gen_count < DEPTH) gen_count++;
    end else if (gen_count > 0) begin
      gen_count--;
    end
  endtask

  function automatic deq_op_t pick_push();
    return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
  endfunction

  function automatic deq_op_t pick_pop();
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run (~425 transactions, each with the longest
  // idle gap and the longest stall, plus the drain pauses).
  initial begin
    #400000;
    $display("** double_ended_queue_core: FAILED **");
    $finish;
  end

  // Driver: presents pending requests, with random idle bursts on the request side.
  int gap_left;

  always @(posedge clk) begin
    bit presenting;
    bit go;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      presenting = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        void'(pending_req_q.pop_front());
        presenting = 0;
      end
      // A presented request stays put until it is accepted.
      if (!presenting) begin
        go = 0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_req_q.size() > 0) begin
          if (pending_req_q[0].drain_first && (in_ch.valid || n_sent != n_recv)) begin
            go = 0;  // pressure point: let the queue's output side run dry first
          end else if (pending_req_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 13) - 1;
          end else begin
            go = 1;
          end
        end
        in_ch.valid <= go;
        if (go) begin
          in_ch.op    <= pending_req_q[0].op;
          in_ch.value <= pending_req_q[0].value;
        end
      end
    end
  end

  // Monitor: predicts on each accepted request, checks each accepted response,
  // and throttles out_ch.ready with random stall bursts.
  int stall_left;

  always @(posedge clk) begin
    deq_resp_t want;
    bit        rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      // Request side first, so a same-edge response would still find its expectation.
      if (in_ch.valid && in_ch.ready) begin
        expected_resp_q.push_back(deq_apply_op(in_ch.op, in_ch.value));
        n_sent <= n_sent + 1;
      end

      if (out_ch.valid && out_ch.ready) begin
        n_recv <= n_recv + 1;
        if (expected_resp_q.size() == 0) begin
          err_count++;
          $error("unexpected response transaction: popped_value %0d status %0d occupancy %0d",
                 out_ch.popped_value, out_ch.status, out_ch.occupancy);
        end else begin
          want = expected_resp_q.pop_front();
          if (out_ch.popped_value !== want.popped_value) begin
            err_count++;
            $error("popped_value: expected %0d, got %0d", want.popped_value,
                   out_ch.popped_value);
          end
          if (out_ch.status !== want.status) begin
            err_count++;
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
          end
          if (out_ch.occupancy !== want.occupancy) begin
            err_count++;
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_ch.occupancy);
          end
          case (want.status)
            ST_FULL:  n_full++;
            ST_EMPTY: n_empty++;
            default:  ;
          endcase
          if (int'(want.occupancy) > peak_occ) peak_occ = want.occupancy;
        end
      end

      if (stall_left > 0) begin
        stall_left--;
        rdy = 0;
      end else if (n_recv < total_reqs - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        rdy = 0;
      end else begin
        rdy = 1;
      end
      out_ch.ready <= rdy;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int kind;
    int len;

    in_ch.valid  = 1'b0;
    in_ch.op     = OP_PUSH_FRONT;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    n_sent = 0; n_recv = 0; err_count = 0; gen_count = 0; hold_next = 0;
    front_mdl = 0; count_mdl = 0;
    n_push = 0; n_pop = 0; n_full = 0; n_empty = 0; peak_occ = 0;

    // Directed: pops on an empty queue, extreme words, front index wrapping below
    // zero, fill to the brim, pushes into a full queue, then pops from both ends.
    add_req(OP_POP_FRONT, pick_word());
    add_req(OP_POP_REAR, pick_word());
    add_req(OP_PUSH_FRONT, 32'sh7fff_ffff);
    add_req(OP_PUSH_REAR, 32'sh8000_0000);
    add_req(OP_PUSH_FRONT, -32'sd1);
    add_req(OP_PUSH_REAR, '0);
    for (int i = 0; i < DEPTH - 4; i++)
      add_req(i % 2 ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_word());
    add_req(OP_PUSH_FRONT, pick_word());
    add_req(OP_PUSH_REAR, pick_word());
    add_req(OP_POP_REAR, pick_word());
    add_req(OP_POP_FRONT, pick_word());

    // Random: fill episodes to full, drain episodes to empty, and mixed noise.
    hold_next = 1;
    begin
      int base;
      bit mid_hold_done;
      base = pending_req_q.size();
      mid_hold_done = 0;
      while (pending_req_q.size() - base < RAND_ITEMS) begin
        if (!mid_hold_done && pending_req_q.size() - base > RAND_ITEMS / 2) begin
          hold_next = 1;
          mid_hold_done = 1;
        end
        kind = $urandom_range(0, 3);
        if (kind == 0) begin
          while (gen_count < DEPTH) begin
            if ($urandom_range(0, 5) == 0) add_req(pick_pop(), pick_word());
            else add_req(pick_push(), pick_word());
          end
          len = $urandom_range(0, 2);
          repeat (len) add_req(pick_push(), pick_word());
        end else if (kind == 1) begin
          while (gen_count > 0) begin
            if ($urandom_range(0, 5) == 0) add_req(pick_push(), pick_word());
            else add_req(pick_pop(), pick_word());
          end
          len = $urandom_range(0, 2);
          repeat (len) add_req(pick_pop(), pick_word());
        end else begin
          len = $urandom_range(5, 20);
          repeat (len) add_req(deq_op_t'($urandom_range(0, 3)), pick_word());
        end
      end
    end
    total_reqs = pending_req_q.size();
    foreach (pending_req_q[i]) begin
      if (pending_req_q[i].op inside {OP_PUSH_FRONT, OP_PUSH_REAR}) n_push++;
      else n_pop++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Everything driven and answered, then a short quiet window for stray responses.
    do @(negedge clk); while (n_sent < total_reqs || n_recv < n_sent);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (expected_resp_q.size() != 0) begin
      err_count++;
      $error("%0d responses never arrived", expected_resp_q.size());
    end

    $display("Ran %0d transactions (%0d pushes, %0d pops) under random idling and stalls.",
             n_sent, n_push, n_pop);
    $display("Saw %0d full and %0d empty responses, peak occupancy %0d, %0d mismatches.",
             n_full, n_empty, peak_occ, err_count);
    if (err_count == 0) begin
      $display("** double_ended_queue_core: PASSED **");
    end else begin
      $display("** double_ended_queue_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: double_ended_queue_core.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_if.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue_core.sv
tb/double_ended_queue_core_tb.sv
